@@ sv/thermal_frame_change_detector_defines.svh @@
// Assertion macros shared by the thermal frame change detector RTL.
`ifndef THERMAL_FRAME_CHANGE_DETECTOR_DEFINES_SVH
`define THERMAL_FRAME_CHANGE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THFCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define THFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/thfcd_pkg.sv @@
// Package: constants, types and register indexes of the thermal frame change detector.
`timescale 1ns / 1ps
`default_nettype none

package thfcd_pkg;

    localparam int PIXELS         = 64;
    localparam int HISTORY_FRAMES = 4;

    localparam int POS_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SLOT_W  = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
    localparam int DEPTH   = PIXELS * HISTORY_FRAMES;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // holds HISTORY_FRAMES * 508 and the slot sum
    localparam int THR_W   = 9 + $clog2(HISTORY_FRAMES + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int COUNT_W   = 7;

    localparam logic [7:0]         PIX_MAX   = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANGE_DEGREES     = 2'd0,
        REG_CHANGE_PIXEL_COUNT = 2'd1,
        REG_READING_OFFSET     = 2'd2,
        REG_SEND_FIRST_FRAME   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ sv/thermal_frame_change_detector.sv @@
// Top level: thermal pixel offset/clamp, per-pixel history and frame change decision.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in      | in  | in_valid / in_ready  | raw_low, raw_high, start_of_frame
//  out     | out | out_valid / out_ready| pixel_value, frame_end, publish_frame
//  cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One word at a time. Priming frame: one RAM write per history slot for each
// word. Primed frames: paced by the single RAM read port (one slot read per
// cycle, plus registered read data). in_ready is high only in idle; a finished
// result waits in the output register while the next word is accepted. Reset
// clears control state; history RAM is left as is and is fully written by the
// priming frame before any read.
`timescale 1ns / 1ps
`default_nettype none
`include "thermal_frame_change_detector_defines.svh"

module thermal_frame_change_detector (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input pixel channel
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire logic [7:0]                         raw_low,
    input  wire logic [3:0]                         raw_high,
    input  wire logic                               start_of_frame,
    // result channel
    output      logic                               out_valid,
    input  wire logic                               out_ready,
    output      logic [7:0]                         pixel_value,
    output      logic                               frame_end,
    output      logic                               publish_frame,
    // configuration channel
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [thfcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [thfcd_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int POS_W   = thfcd_pkg::POS_W;
    localparam int SLOT_W  = thfcd_pkg::SLOT_W;
    localparam int ADDR_W  = thfcd_pkg::ADDR_W;
    localparam int THR_W   = thfcd_pkg::THR_W;
    localparam int COUNT_W = thfcd_pkg::COUNT_W;

    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(thfcd_pkg::PIXELS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(thfcd_pkg::HISTORY_FRAMES - 1);
    localparam logic [THR_W-1:0]  HF_MUL    = THR_W'(thfcd_pkg::HISTORY_FRAMES);

    // configuration registers
    logic [5:0]         cd_reg;
    logic [6:0]         cpc_reg;
    logic signed [7:0]  ofs_reg;
    logic               sff_reg;

    // control state
    thfcd_pkg::state_t  state_reg, state_next;
    logic [POS_W-1:0]   position_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               primed_reg;
    logic [SLOT_W-1:0]  k_reg;
    logic               rd_vld_reg;
    logic               out_valid_reg;

    // per-word working registers
    logic [POS_W-1:0]   pos_reg;
    logic [7:0]         pix_reg;
    logic               is_end_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic [THR_W-1:0]   acc_reg;
    logic [THR_W-1:0]   hi_reg;
    logic [THR_W-1:0]   lo_reg;
    logic               lo_ok_reg;
    logic [7:0]         pixel_value_reg;
    logic               frame_end_reg;
    logic               publish_reg;

    // combinational
    logic               accept;
    logic               done_go;
    logic               rd_issue;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [7:0]         mem_rdata;
    logic [ADDR_W-1:0]  base;
    logic signed [12:0] sum;
    logic [7:0]         pix;
    logic [POS_W-1:0]   pos_sel;
    logic [7:0]         thr;
    logic [8:0]         hi_arg;
    logic [8:0]         lo_arg;
    logic               dev;
    logic [COUNT_W-1:0] count_new;

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign pixel_value   = pixel_value_reg;
    assign frame_end     = frame_end_reg;
    assign publish_frame = publish_reg;

    assign accept  = in_valid && in_ready;
    assign done_go = (state_reg == thfcd_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // sign-extended reading plus offset, clamped to 0..255
    assign sum = 13'(signed'({raw_high, raw_low})) + 13'(ofs_reg);
    always_comb
    begin
        priority if (sum < 0)
            pix = 8'd0;
        else if (sum > 13'sd255)
            pix = thfcd_pkg::PIX_MAX;
        else
            pix = sum[7:0];
    end

    assign pos_sel = start_of_frame ? '0 : position_reg;
    assign base    = ADDR_W'(ADDR_W'(pos_reg) * ADDR_W'(thfcd_pkg::HISTORY_FRAMES));

    // deviation bounds: floor(acc/HF) > pix+T  <=>  acc >= HF*(pix+T+1)
    //                   floor(acc/HF) < pix-T  <=>  acc <  HF*(pix-T)
    assign thr    = {cd_reg, 2'b00};
    assign hi_arg = 9'(pix_reg) + 9'(thr) + 9'd1;
    assign lo_arg = 9'(pix_reg) - 9'(thr);

    assign dev = (acc_reg >= hi_reg) || (lo_ok_reg && (acc_reg < lo_reg));
    assign count_new = (dev && (count_reg != thfcd_pkg::COUNT_MAX)) ?
                       count_reg + COUNT_W'(1) : count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            thfcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = primed_reg ? thfcd_pkg::ST_READ : thfcd_pkg::ST_PRIME;
            end
            thfcd_pkg::ST_PRIME:
            begin
                if (k_reg == LAST_SLOT)
                    state_next = thfcd_pkg::ST_DONE;
            end
            thfcd_pkg::ST_READ:
            begin
                if (k_reg == LAST_SLOT)
                    state_next = thfcd_pkg::ST_DRAIN;
            end
            thfcd_pkg::ST_DRAIN:
            begin
                state_next = thfcd_pkg::ST_DONE;
            end
            thfcd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = thfcd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = thfcd_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs: handshake and RAM port control
    always_comb
    begin
        in_ready  = 1'b0;
        rd_issue  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = base;
        mem_raddr = base + ADDR_W'(k_reg);
        unique case (state_reg)
            thfcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            thfcd_pkg::ST_PRIME:
            begin
                // priming fills every slot of the pixel
                mem_we    = 1'b1;
                mem_waddr = base + ADDR_W'(k_reg);
            end
            thfcd_pkg::ST_READ:
            begin
                rd_issue = 1'b1;
            end
            thfcd_pkg::ST_DRAIN:
            begin
                mem_we = 1'b0;
            end
            thfcd_pkg::ST_DONE:
            begin
                // current slot gets the new pixel; it was read as pix_reg already
                mem_we    = primed_reg;
                mem_waddr = base + ADDR_W'(slot_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    thfcd_hist_ram u_hist_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (pix_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg  <= 6'd1;
            cpc_reg <= 7'd1;
            ofs_reg <= 8'sd0;
            sff_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (thfcd_pkg::cfg_idx_t'(cfg_index))
                thfcd_pkg::REG_CHANGE_DEGREES:     cd_reg  <= cfg_data[5:0];
                thfcd_pkg::REG_CHANGE_PIXEL_COUNT: cpc_reg <= cfg_data[6:0];
                thfcd_pkg::REG_READING_OFFSET:     ofs_reg <= signed'(cfg_data[7:0]);
                thfcd_pkg::REG_SEND_FIRST_FRAME:   sff_reg <= cfg_data[0];
                default:                           cd_reg  <= cd_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= thfcd_pkg::ST_IDLE;
            position_reg  <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            primed_reg    <= 1'b0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_issue;

            if (accept)
            begin
                k_reg        <= '0;
                position_reg <= (pos_sel == LAST_POS) ? '0 : pos_sel + POS_W'(1);
                if (pos_sel == '0)
                    count_reg <= '0;
            end
            else if ((state_reg == thfcd_pkg::ST_PRIME) || (state_reg == thfcd_pkg::ST_READ))
            begin
                k_reg <= k_reg + SLOT_W'(1);
            end

            if (out_valid_reg && out_ready && !done_go)
                out_valid_reg <= 1'b0;

            if (done_go)
            begin
                out_valid_reg <= 1'b1;
                if (primed_reg)
                begin
                    count_reg <= count_new;
                    if (is_end_reg)
                        slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                end
                else if (is_end_reg)
                begin
                    primed_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg    <= pos_sel;
            pix_reg    <= pix;
            is_end_reg <= (pos_sel == LAST_POS);
            acc_reg    <= '0;
        end
        else if (rd_vld_reg)
        begin
            acc_reg <= acc_reg + ((rd_slot_reg == slot_reg) ? THR_W'(pix_reg) :
                                                              THR_W'(mem_rdata));
        end

        rd_slot_reg <= k_reg;

        if (state_reg == thfcd_pkg::ST_READ)
        begin
            hi_reg    <= THR_W'(THR_W'(hi_arg) * HF_MUL);
            lo_reg    <= THR_W'(THR_W'(lo_arg) * HF_MUL);
            lo_ok_reg <= (pix_reg > thr);
        end

        if (done_go)
        begin
            pixel_value_reg <= pix_reg;
            frame_end_reg   <= is_end_reg;
            if (!is_end_reg)
                publish_reg <= 1'b0;
            else if (primed_reg)
                publish_reg <= (count_new >= cpc_reg);
            else
                publish_reg <= sff_reg;
        end
    end

    // assertions
    `THFCD_ASSERT_NOW(a_ready_no_read, clk, rst_n, in_ready, !rd_vld_reg, "read in flight while ready")
    `THFCD_ASSERT_NOW(a_publish_end, clk, rst_n, out_valid && publish_frame, frame_end, "publish without frame end")
    `THFCD_ASSERT_NEXT(a_accept_path, clk, rst_n, accept, (state_reg == thfcd_pkg::ST_PRIME) || (state_reg == thfcd_pkg::ST_READ), "accepted word not processed")
    `THFCD_ASSERT_NOW(a_primed_stays, clk, rst_n, 1'b1, !$fell(primed_reg), "primed flag dropped")

endmodule

`default_nettype wire

@@ sv/thfcd_hist_ram.sv @@
// History RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module thfcd_hist_ram (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [thfcd_pkg::ADDR_W-1:0]  waddr,
    input  wire logic [7:0]                    wdata,
    input  wire logic [thfcd_pkg::ADDR_W-1:0]  raddr,
    output      logic [7:0]                    rdata
);

    logic [7:0] mem [thfcd_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the thermal frame change detector.
`timescale 1ns / 1ps

module tb_top;
    import thfcd_pkg::*;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 10;    // lets the block finish its last word
    localparam int ITEM_TARGET   = 1650;
    localparam int PRINT_LIMIT   = 100;

    // one result word as the block presents it
    typedef struct packed {
        logic [7:0] pixel_value;
        logic       frame_end;
        logic       publish_frame;
    } pixel_word_t;

    // Tracks registers, per-pixel history and frame position; predicts each
    // result word at input acceptance and checks words in arrival order.
    class frame_change_scoreboard;
        logic [7:0]  history_mem [PIXELS * HISTORY_FRAMES];
        int          slot;
        int          position;
        int          deviating;
        bit          primed;
        int          degrees;
        int          pixel_count;
        int          offset;
        bit          send_first;
        pixel_word_t words_in_flight [$];
        int          mismatches;

        function new();
            foreach (history_mem[i]) history_mem[i] = 8'd0;
            slot        = 0;
            position    = 0;
            deviating   = 0;
            primed      = 1'b0;
            degrees     = 1;
            pixel_count = 1;
            offset      = 0;
            send_first  = 1'b1;
            mismatches  = 0;
        endfunction

        function void take_setting(cfg_idx_t idx, logic [7:0] data);
            case (idx)
                REG_CHANGE_DEGREES:     degrees     = int'(data[5:0]);
                REG_CHANGE_PIXEL_COUNT: pixel_count = int'(data[6:0]);
                REG_READING_OFFSET:     offset      = int'($signed(data));
                REG_SEND_FIRST_FRAME:   send_first  = data[0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [7:0] lo, logic [3:0] hi, logic sof);
            logic signed [11:0] reading;
            int                 total;
            int                 base;
            int                 acc;
            int                 avg;
            int                 diff;
            pixel_word_t        word;
            reading = {hi, lo};
            total   = int'(reading) + offset;
            if (total < 0)
                word.pixel_value = 8'd0;
            else if (total > 255)
                word.pixel_value = PIX_MAX;
            else
                word.pixel_value = total[7:0];
            if (sof)
                position = 0;
            if (position == 0)
                deviating = 0;
            base = position * HISTORY_FRAMES;
            if (!primed) begin
                for (int k = 0; k < HISTORY_FRAMES; k++)
                    history_mem[base + k] = word.pixel_value;
            end
            else begin
                history_mem[base + slot] = word.pixel_value;
                acc = 0;
                for (int k = 0; k < HISTORY_FRAMES; k++)
                    acc += int'(history_mem[base + k]);
                avg  = acc / HISTORY_FRAMES;
                diff = (avg > int'(word.pixel_value)) ? avg - int'(word.pixel_value)
                                                      : int'(word.pixel_value) - avg;
                // a frame holds at most PIXELS deviations, so 127 is never reached
                if (diff > degrees * 4 && deviating < int'(COUNT_MAX))
                    deviating++;
            end
            word.frame_end     = (position == PIXELS - 1);
            word.publish_frame = 1'b0;
            if (word.frame_end) begin
                if (!primed) begin
                    primed             = 1'b1;
                    word.publish_frame = send_first;
                end
                else begin
                    word.publish_frame = (deviating >= pixel_count);
                    slot               = (slot + 1) % HISTORY_FRAMES;
                end
                position = 0;
            end
            else begin
                position++;
            end
            words_in_flight.push_back(word);
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_LIMIT)
                $display("%0d ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [7:0] pix, logic fe, logic pub);
            pixel_word_t want;
            if (words_in_flight.size() == 0) begin
                report_mismatch($sformatf("word with none pending, pixel_value %0d", pix));
                return;
            end
            want = words_in_flight.pop_front();
            if (pix !== want.pixel_value)
                report_mismatch($sformatf("pixel_value %0d, want %0d", pix, want.pixel_value));
            if (fe !== want.frame_end)
                report_mismatch($sformatf("frame_end %b, want %b", fe, want.frame_end));
            if (pub !== want.publish_frame)
                report_mismatch($sformatf("publish_frame %b, want %b", pub,
                                          want.publish_frame));
        endtask

        function int in_flight();
            return words_in_flight.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           raw_low;
    logic [3:0]           raw_high;
    logic                 start_of_frame;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           pixel_value;
    logic                 frame_end;
    logic                 publish_frame;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    frame_change_scoreboard sb = new();

    logic calm = 1'b0;       // set for phases with no idling on either side
    int   items_sent = 0;
    int   quiet_cycles = 0;
    int   scene [PIXELS];    // slowly changing picture, readings per pixel

    thermal_frame_change_detector i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_low        (raw_low),
        .raw_high       (raw_high),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_value    (pixel_value),
        .frame_end      (frame_end),
        .publish_frame  (publish_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor and watchdog. Handshakes are sampled at the edge, before any
    // nonblocking update lands, so the order of processes does not matter.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_pixel(raw_low, raw_high, start_of_frame);
            if (out_valid && out_ready)
                sb.check_result(pixel_value, frame_end, publish_frame);
            if (cfg_valid && cfg_ready)
                sb.take_setting(cfg_idx_t'(cfg_index), cfg_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: random stall before each word, none in calm phases.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Sends one pixel word; valid stays high afterwards unless the next call
    // draws a gap, so valid is never dropped and raised in one step.
    task automatic push_pixel(input logic [11:0] raw, input logic sof);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        raw_low        <= raw[7:0];
        raw_high       <= raw[11:8];
        start_of_frame <= sof;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Holds the sender until every pending word is out, then lets the block
    // finish its last word before anything else happens.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.in_flight() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes a setting; unless every is set, each register is skipped at
    // random. Unused upper data bits sometimes carry junk.
    task automatic apply_setting(input int degrees, input int count, input int offset,
                                 input bit first, input bit every);
        logic [7:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
        if (every || $urandom_range(0, 3) != 0)
            write_reg(REG_CHANGE_DEGREES, 8'(degrees) | (junk & 8'hC0));
        if (every || $urandom_range(0, 3) != 0)
            write_reg(REG_CHANGE_PIXEL_COUNT, 8'(count) | (junk & 8'h80));
        if (every || $urandom_range(0, 3) != 0)
            write_reg(REG_READING_OFFSET, 8'(offset));
        if (every || $urandom_range(0, 3) != 0)
            write_reg(REG_SEND_FIRST_FRAME, {7'd0, first} | (junk & 8'hFE));
        cfg_valid <= 1'b0;
    endtask

    // Moves part of the picture so that some frames count as changed.
    task automatic shift_scene();
        int moved;
        int idx;
        moved = $urandom_range(0, PIXELS);
        for (int i = 0; i < moved; i++) begin
            idx        = $urandom_range(0, PIXELS - 1);
            scene[idx] = scene[idx] + int'($urandom_range(0, 400)) - 200;
            if (scene[idx] < -100)
                scene[idx] = -100;
            if (scene[idx] > 400)
                scene[idx] = 400;
        end
    endtask

    // One frame of len words; wild frames use fully random readings.
    task automatic send_frame(input int len, input bit sof_first, input bit wild);
        int          jitter;
        int          reading;
        logic [11:0] raw;
        jitter = $urandom_range(0, 12);
        for (int p = 0; p < len; p++) begin
            if (wild) begin
                raw = 12'($urandom);
            end
            else begin
                reading = scene[p] + int'($urandom_range(0, 2 * jitter)) - jitter;
                raw     = reading[11:0];
            end
            push_pixel(raw, (p == 0) ? sof_first : 1'b0);
        end
    endtask

    initial
    begin
        int phase;
        int len;
        bit whole_prev;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        raw_low        <= 8'd0;
        raw_high       <= 4'd0;
        start_of_frame <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_CHANGE_DEGREES;
        cfg_data       <= 8'd0;
        foreach (scene[i]) scene[i] = int'($urandom_range(0, 360)) - 50;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reading extremes at reset setting, a frame restart in the
        // middle of a partial frame, then clamping at both offset extremes.
        push_pixel(12'h000, 1'b1);
        push_pixel(12'h7FF, 1'b0);   // largest reading, clamps high
        push_pixel(12'h800, 1'b0);   // most negative reading, clamps low
        push_pixel(12'hFFF, 1'b0);   // minus one
        push_pixel(12'h0FF, 1'b0);
        push_pixel(12'h100, 1'b0);   // just above the byte range
        push_pixel(12'h0A5, 1'b1);   // restart drops the partial frame
        push_pixel(12'h45A, 1'b0);
        push_pixel(12'hBAD, 1'b0);
        push_pixel(12'h001, 1'b0);
        drain_and_settle();
        apply_setting(1, 1, 127, 1'b1, 1'b1);
        push_pixel(12'h080, 1'b1);   // lands on 255
        push_pixel(12'h081, 1'b0);   // one past, clamps
        push_pixel(12'hF81, 1'b0);   // lands on 0
        push_pixel(12'hF80, 1'b0);   // one below, clamps
        drain_and_settle();
        apply_setting(1, 1, -128, 1'b1, 1'b1);
        push_pixel(12'h17F, 1'b1);
        push_pixel(12'h180, 1'b0);
        push_pixel(12'h080, 1'b0);
        push_pixel(12'h07F, 1'b0);
        push_pixel(12'h7FF, 1'b0);
        push_pixel(12'h0FF, 1'b0);
        drain_and_settle();

        // Random part: phases of whole frames over a moving picture, with
        // some broken frames and stray words. The first whole frame primes
        // the history; the first phases pin the register extremes.
        apply_setting(0, 1, 0, 1'b0, 1'b1);
        whole_prev = 1'b0;
        phase      = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase > 0) begin
                drain_and_settle();
                case (phase)
                    1: apply_setting(63, 64, 127, 1'b1, 1'b1);
                    2: apply_setting(0, 0, -128, 1'b0, 1'b1);
                    3: apply_setting(5, 127, 0, 1'b1, 1'b1);
                    default: apply_setting($urandom_range(0, 63),
                                           ($urandom_range(0, 3) == 0) ? $urandom_range(65, 127)
                                                                       : $urandom_range(0, 64),
                                           int'($urandom_range(0, 255)) - 128,
                                           1'($urandom_range(0, 1)), 1'b0);
                endcase
            end
            calm = (phase > 0) && ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 5))
                        push_pixel(12'($urandom), 1'($urandom_range(0, 1)));
                    whole_prev = 1'b0;
                end
                if ($urandom_range(0, 1) == 0)
                    shift_scene();
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, PIXELS - 1) : PIXELS;
                // after a whole frame the position wraps by itself, so the
                // start marker is sometimes left off
                send_frame(len, !whole_prev || ($urandom_range(0, 3) != 0),
                           $urandom_range(0, 7) == 0);
                whole_prev = (len == PIXELS);
            end
            phase++;
        end
        drain_and_settle();

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/thfcd_pkg.sv
sv/thfcd_hist_ram.sv
sv/thermal_frame_change_detector.sv
tb/sv/tb_top.sv
